[rtl/casi_pkg.sv]
// Shared types and constants for the circular arc step interpolator.
`timescale 1ns / 1ps
package casi_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic ERR_NONE     = 1'b0;
  localparam logic ERR_RADIUS   = 1'b1;

  localparam int unsigned CFG_BITS   = 16;
  localparam logic [CFG_BITS-1:0] MAX_RADIUS_ERROR_RESET = 16'd10;

  // Radius arithmetic wraps modulo 2^64.
  localparam int unsigned ACC_BITS = 64;
  localparam int unsigned ROOT_BITS = 32;

  // Start-time checks travelling to the square root unit.
  typedef struct packed {
    logic                start;
    logic [ACC_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic xy_en;
    logic z_en;
    logic slow;
  } pin_state_t;

endpackage

[rtl/casi_sqmac.sv]
// Bit-serial squaring accumulator: adds d*d to a 64-bit sum, one multiplier bit a cycle.
`timescale 1ns / 1ps
module casi_sqmac #(
  parameter int unsigned W = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          clear_acc,
  input  logic signed [W:0]             operand,
  output logic                          done,
  output logic [casi_pkg::ACC_BITS-1:0] acc
);
  import casi_pkg::*;

  localparam int unsigned MW = W + 1;
  localparam int unsigned CW = $clog2(MW + 1);

  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [ACC_BITS-1:0] mcand_r, mcand_nxt;
  logic [MW-1:0]       mplier_r, mplier_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                run_r, run_nxt;
  logic [MW-1:0]       mag;

  // Magnitude of the operand
  assign mag = operand[W] ? MW'(-operand) : MW'(operand);

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    if (start) begin
      if (clear_acc) acc_nxt = '0;
      mcand_nxt  = ACC_BITS'(mag);
      mplier_nxt = mag;
      cnt_nxt    = CW'(MW);
      run_nxt    = 1'b1;
    end else if (run_r) begin
      if (cnt_r != '0) begin
        // shift-and-add one bit
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - 1'b1;
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  // Sum is complete once every multiplier bit has been added
  assign done = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign acc = acc_r;

endmodule

[rtl/casi_isqrt.sv]
// Digit-serial floor square root, one result bit per cycle.
`timescale 1ns / 1ps
module casi_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  casi_pkg::sqrt_req_t req,
  output casi_pkg::sqrt_rsp_t rsp
);
  import casi_pkg::*;

  localparam int unsigned CW = $clog2(ROOT_BITS + 1);

  logic [ACC_BITS-1:0]  n_r, n_nxt;
  logic [ACC_BITS-1:0]  r_r, r_nxt;
  logic [ACC_BITS-1:0]  b_r, b_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [ACC_BITS-1:0]  trial;

  assign trial = r_r + b_r;

  always_comb begin
    n_nxt    = n_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    if (req.start) begin
      n_nxt   = req.radicand;
      r_nxt   = '0;
      b_nxt   = ACC_BITS'(1) << (ACC_BITS - 2);
      cnt_nxt = CW'(ROOT_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (cnt_r != '0) begin
        // one restoring step
        if (n_r >= trial) begin
          n_nxt = n_r - trial;
          r_nxt = (r_r >> 1) + b_r;
        end else begin
          r_nxt = r_r >> 1;
        end
        b_nxt   = b_r >> 2;
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        run_nxt = 1'b0;
      end
    end
  end

  // Root is complete once every bit has been resolved
  assign rsp.done = run_r && (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
  end

  assign rsp.root = r_r[ROOT_BITS-1:0];

endmodule

[rtl/circular_arc_step_interpolator.sv]
// Top level of the circular arc step interpolator.
// Each item gives one result. A start item runs four serial squarings on
// one shared shift-and-add unit, then two square roots. A tick on a running
// arc runs four squarings; a tick while idle runs none. No new item is
// taken while one is in work. The result sits in an output register
// until transferred and the next item is taken meanwhile; a result that
// finds that register still full waits for it, stalling the input.
`timescale 1ns / 1ps
module circular_arc_step_interpolator #(
  parameter int unsigned POS_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_max_radius_error,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic signed [POS_BITS-1:0] in_pos_x,
  input  logic signed [POS_BITS-1:0] in_pos_y,
  input  logic signed [POS_BITS-1:0] in_pos_z,
  input  logic signed [POS_BITS-1:0] in_dest_x,
  input  logic signed [POS_BITS-1:0] in_dest_y,
  input  logic signed [POS_BITS-1:0] in_dest_z,
  input  logic signed [POS_BITS-1:0] in_center_x,
  input  logic signed [POS_BITS-1:0] in_center_y,
  input  logic                      in_counter_clockwise,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_busy_res,
  output logic                      out_error_code,
  output logic                      out_pulse_x,
  output logic                      out_pulse_y,
  output logic                      out_pulse_z,
  output logic                      out_dir_x,
  output logic                      out_dir_y,
  output logic                      out_dir_z,
  output logic                      out_xy_enabled,
  output logic                      out_z_enabled,
  output logic                      out_slow_rate
);
  import casi_pkg::*;

  localparam int unsigned PW = POS_BITS;
  localparam int unsigned DW = POS_BITS + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_ROOT1 = 4'd2;
  localparam logic [3:0] S_ROOT2 = 4'd3;
  localparam logic [3:0] S_SDONE = 4'd4;
  localparam logic [3:0] S_TDONE = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;

  // Configuration and arc state
  logic [CFG_BITS-1:0] max_err_r;
  logic                active_r, started_r, ccw_r;
  logic [ACC_BITS-1:0] target_r;
  logic signed [PW-1:0] cx_r, cy_r, ex_r, ey_r, ez_r;
  pin_state_t          pins_r;

  // Latched item
  logic                op_r, ccwin_r;
  logic signed [PW-1:0] px_r, py_r, pz_r, dx_r, dy_r, dz_r, icx_r, icy_r;

  logic [3:0]          state_r;
  logic [2:0]          sq_idx_r;
  logic [ACC_BITS-1:0] r_end_r, a_root_r;
  logic [ACC_BITS-1:0] cxs_r, cys_r, sxr_r, syr_r;

  // Staged result and output register
  logic out_valid_r, busy_o_r, err_o_r, sx_o_r, sy_o_r, sz_o_r;
  logic res_busy_r, res_err_r, res_px_r, res_py_r, res_pz_r;
  pin_state_t pins_out;

  // Tick geometry
  logic signed [DW-1:0] xr, yr;
  logic                 stx_pos, sty_pos;
  assign xr = DW'(px_r) - DW'(cx_r);
  assign yr = DW'(py_r) - DW'(cy_r);

  always_comb begin
    if (!ccw_r) begin
      stx_pos = (xr >= 0 && yr < 0) || (xr < 0 && yr <= 0);
      sty_pos = (xr >= 0 && yr < 0) || (xr > 0 && yr >= 0);
    end else begin
      stx_pos = (xr > 0 && yr >= 0) || (xr <= 0 && yr > 0);
      sty_pos = (xr < 0 && yr <= 0) || (xr <= 0 && yr > 0);
    end
  end

  logic xy_fin, z_fin;
  assign xy_fin = (px_r == ex_r) && (py_r == ey_r);
  assign z_fin  = (pz_r == ez_r);

  // Squaring unit operand selection, for the squaring being launched
  logic                 mac_start, mac_clear, mac_done;
  logic signed [DW-1:0] mac_op;
  logic [ACC_BITS-1:0]  mac_acc;
  logic [2:0]           op_idx;

  assign op_idx = (sq_idx_r == 3'd4) ? 3'd0 : sq_idx_r + 3'd1;

  always_comb begin
    mac_op = '0;
    if (op_r == OP_START) begin
      unique case (op_idx)
        3'd0:    mac_op = DW'(dx_r) - DW'(icx_r);
        3'd1:    mac_op = DW'(dy_r) - DW'(icy_r);
        3'd2:    mac_op = DW'(px_r) - DW'(icx_r);
        default: mac_op = DW'(py_r) - DW'(icy_r);
      endcase
    end else begin
      unique case (op_idx)
        3'd0:    mac_op = xr + (stx_pos ? DW'(1) : -DW'(1));
        3'd1:    mac_op = yr + (sty_pos ? DW'(1) : -DW'(1));
        3'd2:    mac_op = xr;
        default: mac_op = yr;
      endcase
    end
  end

  casi_sqmac #(.W(DW-1)) u_sqmac (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mac_start),
    .clear_acc (mac_clear),
    .operand   (mac_op),
    .done      (mac_done),
    .acc       (mac_acc)
  );

  sqrt_req_t sreq;
  sqrt_rsp_t srsp;
  casi_isqrt u_isqrt (
    .clk (clk),
    .rst_n (rst_n),
    .req (sreq),
    .rsp (srsp)
  );

  logic [ACC_BITS-1:0] ex_e, exy_e, ey_e, rx, rxy, ry, root_a, root_b, rdiff;
  assign rx  = cxs_r + syr_r;
  assign rxy = cxs_r + cys_r;
  assign ry  = sxr_r + cys_r;
  assign ex_e  = (target_r > rx)  ? target_r - rx  : rx  - target_r;
  assign exy_e = (target_r > rxy) ? target_r - rxy : rxy - target_r;
  assign ey_e  = (target_r > ry)  ? target_r - ry  : ry  - target_r;
  assign root_a = a_root_r;
  assign root_b = ACC_BITS'(srsp.root);
  assign rdiff  = (root_a > root_b) ? root_a - root_b : root_b - root_a;

  logic accept, sq_last, out_load;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign sq_last  = (sq_idx_r == 3'd3);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Sequencer
  always_comb begin
    mac_start   = 1'b0;
    mac_clear   = 1'b0;
    sreq.start  = 1'b0;
    sreq.radicand = r_end_r;
    if (state_r == S_SQ && sq_idx_r == 3'd4) begin
      mac_start = 1'b1;
      mac_clear = 1'b1;
    end
    if (state_r == S_SQ && mac_done && !sq_last) begin
      mac_start = 1'b1;
      mac_clear = (op_r == OP_TICK) || (sq_idx_r == 3'd1);
    end
    if (state_r == S_SQ && mac_done && sq_last && op_r == OP_START) begin
      sreq.start = 1'b1;
      sreq.radicand = r_end_r;
    end
    if (state_r == S_ROOT1 && srsp.done) begin
      sreq.start = 1'b1;
      sreq.radicand = mac_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sq_idx_r    <= '0;
      max_err_r   <= MAX_RADIUS_ERROR_RESET;
      active_r    <= 1'b0;
      started_r   <= 1'b0;
      ccw_r       <= 1'b0;
      target_r    <= '0;
      cx_r <= '0; cy_r <= '0; ex_r <= '0; ey_r <= '0; ez_r <= '0;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_err_r <= cfg_max_radius_error;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r <= in_opcode; ccwin_r <= in_counter_clockwise;
            px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
            dx_r <= in_dest_x; dy_r <= in_dest_y; dz_r <= in_dest_z;
            icx_r <= in_center_x; icy_r <= in_center_y;
            sq_idx_r <= 3'd4;
            state_r  <= (in_opcode == OP_START || active_r) ? S_SQ : S_TDONE;
          end
        end
        S_SQ: begin
          if (sq_idx_r == 3'd4) sq_idx_r <= 3'd0;
          else if (mac_done) begin
            if (op_r == OP_TICK) begin
              unique case (sq_idx_r)
                3'd0:    cxs_r <= mac_acc;
                3'd1:    cys_r <= mac_acc;
                3'd2:    sxr_r <= mac_acc;
                default: syr_r <= mac_acc;
              endcase
            end else if (sq_idx_r == 3'd1) begin
              r_end_r <= mac_acc;
            end
            if (sq_idx_r == 3'd1 && op_r == OP_START) begin
              sq_idx_r <= 3'd2;
              state_r  <= S_SQ;
            end else if (sq_last) begin
              state_r <= (op_r == OP_START) ? S_ROOT1 : S_TDONE;
            end else begin
              sq_idx_r <= sq_idx_r + 3'd1;
            end
          end
        end
        S_ROOT1: begin
          if (srsp.done) begin
            a_root_r <= root_b;
            state_r  <= S_ROOT2;
          end
        end
        S_ROOT2: begin
          if (srsp.done) state_r <= S_SDONE;
        end
        S_SDONE: begin
          // resolve a start
          ccw_r     <= ccwin_r;
          started_r <= 1'b0;
          cx_r <= icx_r; cy_r <= icy_r;
          sx_o_r <= 1'b0; sy_o_r <= 1'b0; sz_o_r <= 1'b0;
          if (rdiff > ACC_BITS'(max_err_r)) begin
            err_o_r  <= ERR_RADIUS;
            busy_o_r <= 1'b0;
            active_r <= 1'b0;
          end else begin
            err_o_r  <= ERR_NONE;
            busy_o_r <= 1'b1;
            active_r <= 1'b1;
            target_r <= r_end_r;
            pins_r.dir_z <= dz_r > pz_r;
            pins_r.xy_en <= 1'b1;
            if (dz_r != pz_r) pins_r.z_en <= 1'b1;
            pins_r.slow <= 1'b0;
            ex_r <= dx_r; ey_r <= dy_r; ez_r <= dz_r;
          end
          state_r <= S_OUT;
        end
        S_TDONE: begin
          // resolve a tick
          err_o_r <= ERR_NONE;
          sx_o_r <= 1'b0; sy_o_r <= 1'b0; sz_o_r <= 1'b0;
          busy_o_r <= 1'b0;
          if (active_r) begin
            busy_o_r <= 1'b1;
            if (xy_fin && z_fin && started_r) begin
              pins_r.z_en <= 1'b0;
              active_r    <= 1'b0;
              busy_o_r    <= 1'b0;
            end else begin
              started_r <= 1'b1;
              if (!z_fin) begin
                sz_o_r <= 1'b1;
                if (xy_fin) pins_r.slow <= 1'b1;
              end else begin
                pins_r.z_en <= 1'b0;
              end
              if (!(xy_fin && !z_fin)) begin
                pins_r.dir_x <= stx_pos;
                pins_r.dir_y <= sty_pos;
                priority if (ex_e <= exy_e && ex_e <= ey_e) begin
                  sx_o_r <= 1'b1;
                end else if (ey_e <= exy_e && ey_e <= ex_e) begin
                  sy_o_r <= 1'b1;
                end else begin
                  sx_o_r <= 1'b1; sy_o_r <= 1'b1;
                end
              end
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // one transfer slot: wait until previous result has gone
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Move the staged result and a snapshot of the pins into the output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      pins_out   <= pins_r;
      res_busy_r <= busy_o_r;
      res_err_r  <= err_o_r;
      res_px_r   <= sx_o_r;
      res_py_r   <= sy_o_r;
      res_pz_r   <= sz_o_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_busy_res   = res_busy_r;
  assign out_error_code = res_err_r;
  assign out_pulse_x    = res_px_r;
  assign out_pulse_y    = res_py_r;
  assign out_pulse_z    = res_pz_r;
  assign out_dir_x      = pins_out.dir_x;
  assign out_dir_y      = pins_out.dir_y;
  assign out_dir_z      = pins_out.dir_z;
  assign out_xy_enabled = pins_out.xy_en;
  assign out_z_enabled  = pins_out.z_en;
  assign out_slow_rate  = pins_out.slow;

endmodule

[rtl/casi_checker.sv]
// Port-level checks for the circular arc step interpolator, bound to the top level.
`timescale 1ns / 1ps
module casi_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_busy_res,
  input logic out_error_code,
  input logic out_pulse_x,
  input logic out_pulse_y,
  input logic out_pulse_z
);
  // A refused start is never busy
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> !out_busy_res) else $error("error with busy");

  // Pulses only while an arc runs
  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pulse_x || out_pulse_y || out_pulse_z) |-> out_busy_res)
    else $error("pulse while idle");

  // An error result carries no pulse
  a_err_nopulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> !(out_pulse_x || out_pulse_y || out_pulse_z))
    else $error("pulse on error");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable({out_busy_res, out_error_code,
                                        out_pulse_x, out_pulse_y, out_pulse_z}))
    else $error("stalled result changed");

endmodule

bind circular_arc_step_interpolator casi_checker u_casi_checker (
  .clk (clk), .rst_n (rst_n),
  .out_valid (out_valid), .out_stall (out_stall), .out_busy_res (out_busy_res),
  .out_error_code (out_error_code), .out_pulse_x (out_pulse_x),
  .out_pulse_y (out_pulse_y), .out_pulse_z (out_pulse_z)
);

[tb/sv/circular_arc_step_interpolator_tb.sv]
// Self-checking testbench for the circular arc step interpolator.
`timescale 1ns / 1ps
module circular_arc_step_interpolator_tb;
  import casi_pkg::*;

  localparam int unsigned PB = 24;
  localparam int unsigned IDLE_WAIT = 400;
  localparam int unsigned STUCK_LIMIT = 6000;
  localparam int HOLD_LEN = 600;

  typedef struct {
    logic opcode;
    logic signed [PB-1:0] px, py, pz, dx, dy, dz, cx, cy;
    logic ccw;
  } arc_item_t;

  typedef struct {
    logic busy, err, sx, sy, sz;
    pin_state_t pins;
  } step_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_max_radius_error = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = OP_TICK;
  logic signed [PB-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [PB-1:0] in_dest_x = '0, in_dest_y = '0, in_dest_z = '0;
  logic signed [PB-1:0] in_center_x = '0, in_center_y = '0;
  logic in_counter_clockwise = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_busy_res, out_error_code, out_pulse_x, out_pulse_y, out_pulse_z;
  logic out_dir_x, out_dir_y, out_dir_z, out_xy_enabled, out_z_enabled, out_slow_rate;

  circular_arc_step_interpolator #(.POS_BITS(PB)) DUT (.*);

  always #4 clk = ~clk;

  // Predictor state
  logic [15:0] radius_limit;
  logic arc_active, arc_started, arc_ccw;
  longint unsigned target_rsq;
  longint ctr_x, ctr_y, end_x, end_y, end_z;
  pin_state_t pins;

  step_result_t expected_steps[$];
  int mismatches = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int stuck = 0;
  int sent_items = 0;

  // Position the machine has reached, fed back from predicted pulses
  longint mach_x, mach_y, mach_z;

  function automatic longint unsigned sq(longint d);
    longint unsigned m;
    m = (d < 0) ? longint'(-d) : d;
    return m * m;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned gap_of(longint unsigned a, longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Advance the predictor by one item and return its result
  function automatic step_result_t predict_step(arc_item_t it);
    step_result_t r;
    longint px, py, pz, xr, yr, stx, sty;
    longint unsigned r_end, r_org, rx, rxy, ry, ex, exy, ey;
    bit xy_fin, z_fin;
    r = '{default: 1'b0, pins: '0};
    px = it.px; py = it.py; pz = it.pz;
    if (it.opcode == OP_START) begin
      arc_ccw = it.ccw;
      arc_started = 1'b0;
      ctr_x = it.cx; ctr_y = it.cy;
      r_end = sq(longint'(it.dx) - ctr_x) + sq(longint'(it.dy) - ctr_y);
      r_org = sq(px - ctr_x) + sq(py - ctr_y);
      if (gap_of(floor_root(r_end), floor_root(r_org)) > radius_limit) begin
        r.err = ERR_RADIUS;
        arc_active = 1'b0;
      end else begin
        target_rsq = r_end;
        pins.dir_z = longint'(it.dz) > pz;
        pins.xy_en = 1'b1;
        if (longint'(it.dz) != pz) pins.z_en = 1'b1;
        pins.slow = 1'b0;
        end_x = it.dx; end_y = it.dy; end_z = it.dz;
        arc_active = 1'b1;
        r.busy = 1'b1;
      end
    end else if (arc_active) begin
      xy_fin = (px == end_x) && (py == end_y);
      z_fin = (pz == end_z);
      r.busy = 1'b1;
      if (xy_fin && z_fin && arc_started) begin
        pins.z_en = 1'b0;
        arc_active = 1'b0;
        r.busy = 1'b0;
      end else begin
        arc_started = 1'b1;
        if (!z_fin) begin
          r.sz = 1'b1;
          if (xy_fin) pins.slow = 1'b1;
        end else begin
          pins.z_en = 1'b0;
        end
        if (!(xy_fin && !z_fin)) begin
          xr = px - ctr_x; yr = py - ctr_y;
          if (!arc_ccw) begin
            stx = ((xr >= 0 && yr < 0) || (xr < 0 && yr <= 0)) ? 1 : -1;
            sty = ((xr >= 0 && yr < 0) || (xr > 0 && yr >= 0)) ? 1 : -1;
          end else begin
            stx = ((xr > 0 && yr >= 0) || (xr <= 0 && yr > 0)) ? 1 : -1;
            sty = ((xr < 0 && yr <= 0) || (xr <= 0 && yr > 0)) ? 1 : -1;
          end
          rx = sq(xr + stx) + sq(yr);
          rxy = sq(xr + stx) + sq(yr + sty);
          ry = sq(xr) + sq(yr + sty);
          ex = gap_of(target_rsq, rx);
          exy = gap_of(target_rsq, rxy);
          ey = gap_of(target_rsq, ry);
          pins.dir_x = (stx == 1);
          pins.dir_y = (sty == 1);
          if (ex <= exy && ex <= ey) r.sx = 1'b1;
          else if (ey <= exy && ey <= ex) r.sy = 1'b1;
          else begin
            r.sx = 1'b1;
            r.sy = 1'b1;
          end
        end
      end
    end
    r.pins = pins;
    return r;
  endfunction

  // Drive one item and hold it until the transfer; valid stays high afterwards
  task automatic send_item(arc_item_t it);
    step_result_t r;
    in_valid <= 1'b1;
    in_opcode <= it.opcode;
    in_pos_x <= it.px; in_pos_y <= it.py; in_pos_z <= it.pz;
    in_dest_x <= it.dx; in_dest_y <= it.dy; in_dest_z <= it.dz;
    in_center_x <= it.cx; in_center_y <= it.cy;
    in_counter_clockwise <= it.ccw;
    do @(posedge clk); while (in_stall);
    sent_items++;
    r = predict_step(it);
    expected_steps.push_back(r);
    if (it.opcode == OP_TICK) begin
      if (r.sx) mach_x += r.pins.dir_x ? 1 : -1;
      if (r.sy) mach_y += r.pins.dir_y ? 1 : -1;
      if (r.sz) mach_z += r.pins.dir_z ? 1 : -1;
    end
  endtask

  // Random burst gaps on the sending side
  task automatic maybe_gap();
    if ($urandom_range(0, 9) < 2) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (expected_steps.size() > 0) @(posedge clk);
  endtask

  task automatic write_radius_limit(logic [15:0] v);
    in_valid <= 1'b0;
    drain();
    repeat (IDLE_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_max_radius_error <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_limit = v;
  endtask

  function automatic arc_item_t tick_at(longint x, longint y, longint z);
    arc_item_t it;
    it = '{opcode: OP_TICK, px: PB'(x), py: PB'(y), pz: PB'(z), dx: PB'($urandom),
           dy: PB'($urandom), dz: PB'($urandom), cx: PB'($urandom), cy: PB'($urandom),
           ccw: 1'($urandom_range(0, 1))};
    return it;
  endfunction

  function automatic arc_item_t noise_item();
    arc_item_t it;
    it = '{opcode: 1'($urandom_range(0, 1)), px: PB'($urandom), py: PB'($urandom),
           pz: PB'($urandom), dx: PB'($urandom), dy: PB'($urandom), dz: PB'($urandom),
           cx: PB'($urandom), cy: PB'($urandom), ccw: 1'($urandom_range(0, 1))};
    return it;
  endfunction

  // One start followed by ticks that follow the predicted pulses to the end or a cap
  task automatic run_arc(longint cx, longint cy, longint rx, longint ry, bit full,
                         int dz_off, bit ccw, bit skew, bit gaps);
    arc_item_t it;
    int n, cap;
    mach_x = cx + rx; mach_y = cy + ry; mach_z = $urandom_range(0, 1000);
    it.opcode = OP_START; it.ccw = ccw;
    it.cx = PB'(cx); it.cy = PB'(cy);
    it.px = PB'(mach_x + (skew ? longint'($urandom_range(2, 40)) : 0));
    it.py = PB'(mach_y); it.pz = PB'(mach_z);
    mach_x = it.px;
    it.dx = PB'(full ? cx + rx : cx - ry);
    it.dy = PB'(full ? cy + ry : cy + rx);
    it.dz = PB'(mach_z + dz_off);
    send_item(it);
    if (gaps) maybe_gap();
    cap = 12 * int'(rx < 0 ? -rx : rx) + 12 * int'(ry < 0 ? -ry : ry) + 60;
    n = 0;
    while (arc_active && n < cap) begin
      send_item(tick_at(mach_x, mach_y, mach_z));
      if (gaps) maybe_gap();
      n++;
    end
  endtask

  task automatic test_directed();
    arc_item_t it;
    // tick while idle, field extremes on both opcodes
    it = '{opcode: OP_TICK, px: 24'h800000, py: 24'h7fffff, pz: 24'h800000,
           dx: 24'h7fffff, dy: 24'h800000, dz: 24'h7fffff, cx: 24'h800000,
           cy: 24'h7fffff, ccw: 1'b1};
    send_item(it);
    // radius mismatch from far corners, then a start whose radii match
    it.opcode = OP_START;
    send_item(it);
    it = '{opcode: OP_START, px: 24'h7fffff, py: 24'h7fffff, pz: 24'h7fffff,
           dx: 24'h800000, dy: 24'h800000, dz: 24'h800000, cx: 24'h7fffff,
           cy: 24'h800000, ccw: 1'b0};
    send_item(it);
    // full circle from start equal to end, both senses, with and without Z
    run_arc(-5, 7, 3, 0, 1'b1, 0, 1'b0, 1'b0, 1'b0);
    run_arc(100, -100, 0, 2, 1'b1, 3, 1'b1, 1'b0, 1'b0);
    // quarter arcs with Z outlasting XY and Z going down
    run_arc(0, 0, 4, 1, 1'b0, 15, 1'b0, 1'b0, 1'b0);
    run_arc(0, 0, -2, 3, 1'b0, -12, 1'b1, 1'b0, 1'b0);
    // quarter arc without Z
    run_arc(0, 0, 6, 0, 1'b0, 0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic random_arcs(int items);
    int sent0;
    sent0 = sent_items;
    while (sent_items - sent0 < items) begin
      if ($urandom_range(0, 9) < 8)
        run_arc($signed(24'($urandom)) / 2, $signed(24'($urandom)) / 2,
                $signed($urandom_range(0, 16)) - 8, $signed($urandom_range(0, 16)) - 8,
                $urandom_range(0, 4) == 0, $signed($urandom_range(0, 20)) - 10,
                1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0, 1'b1);
      else repeat ($urandom_range(1, 6)) begin
        send_item(noise_item());
        maybe_gap();
      end
    end
  endtask

  task automatic test_config_settings();
    write_radius_limit(16'd0);
    random_arcs(250);
    write_radius_limit(16'hffff);
    random_arcs(250);
    write_radius_limit(16'($urandom_range(1, 30)));
    random_arcs(250);
  endtask

  task automatic test_random_mix();
    write_radius_limit(16'd10);
    random_arcs(700);
  endtask

  task automatic test_noise();
    repeat (120) begin
      send_item(noise_item());
      maybe_gap();
    end
  endtask

  // Block the result side for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_asks++;
    repeat (8) send_item(tick_at(mach_x, mach_y, mach_z));
    run_arc(3, 3, 5, 0, 1'b0, 4, 1'b0, 1'b0, 1'b0);
    in_valid <= 1'b0;
    drain();
    run_arc(-9, 2, 0, -4, 1'b0, 0, 1'b1, 1'b0, 1'b0);
  endtask

  // Result side stall pattern, with a long hold when asked
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if ($urandom_range(0, 3) == 0) out_stall <= 1'b0;
      else out_stall <= $urandom_range(0, 99) < 35;
    end
  end

  task automatic report(string what, logic got, logic exp);
    $display("mismatch on %s at %0t: got %0b, want %0b", what, $time, got, exp);
    mismatches++;
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        report("unexpected result", 1'b1, 1'b0);
      end else begin
        e = expected_steps.pop_front();
        if (out_busy_res !== e.busy) report("busy_res", out_busy_res, e.busy);
        if (out_error_code !== e.err) report("error_code", out_error_code, e.err);
        if (out_pulse_x !== e.sx) report("pulse_x", out_pulse_x, e.sx);
        if (out_pulse_y !== e.sy) report("pulse_y", out_pulse_y, e.sy);
        if (out_pulse_z !== e.sz) report("pulse_z", out_pulse_z, e.sz);
        if (out_dir_x !== e.pins.dir_x) report("dir_x", out_dir_x, e.pins.dir_x);
        if (out_dir_y !== e.pins.dir_y) report("dir_y", out_dir_y, e.pins.dir_y);
        if (out_dir_z !== e.pins.dir_z) report("dir_z", out_dir_z, e.pins.dir_z);
        if (out_xy_enabled !== e.pins.xy_en) report("xy_enabled", out_xy_enabled, e.pins.xy_en);
        if (out_z_enabled !== e.pins.z_en) report("z_enabled", out_z_enabled, e.pins.z_en);
        if (out_slow_rate !== e.pins.slow) report("slow_rate", out_slow_rate, e.pins.slow);
      end
    end
  end

  // Stop a hung run: count cycles with no transfer while work is offered or pending
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) stuck <= 0;
    else if (rst_n && (in_valid || expected_steps.size() > 0)) begin
      stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    radius_limit = MAX_RADIUS_ERROR_RESET;
    arc_active = 0; arc_started = 0; arc_ccw = 0;
    target_rsq = 0; ctr_x = 0; ctr_y = 0; end_x = 0; end_y = 0; end_z = 0;
    pins = '0;
    mach_x = 0; mach_y = 0; mach_z = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_settings();
    test_backpressure();
    test_random_mix();
    test_noise();
    in_valid <= 1'b0;
    drain();
    repeat (IDLE_WAIT) @(posedge clk);
    if (mismatches == 0 && expected_steps.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
